@@ rtl/date_difference_days_core_defines.svh @@
// Assertion macros shared by the date difference RTL.
// Taken in by `include in the files that carry concurrent checks; no dependencies.
`ifndef DATE_DIFFERENCE_DAYS_CORE_DEFINES_SVH
`define DATE_DIFFERENCE_DAYS_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DDD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("date difference check failed");

// Next-cycle implication, disabled while reset is asserted
`define DDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("date difference check failed");

`endif

@@ rtl/ddd_pkg.sv @@
// Shared types, widths and constants for the date difference core.
// No dependencies; used by ddd_ordinal and date_difference_days_core.
`default_nettype none

package ddd_pkg;

    // Field widths
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ORD_W   = 23;   // ordinal day number, year up to 16383
    localparam int DIST_W  = 22;
    localparam int QTR_W   = YEAR_W - 2;
    localparam int PROD_W  = 2 * QTR_W;
    localparam int CENT_W  = 8;    // quotient of quarter years by 25
    localparam int DBM_W   = 9;

    // Packed stream widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // Reciprocal of 25: exact floor for quarter years below 4681
    localparam logic [QTR_W-1:0] RECIP_25    = QTR_W'(2622);
    localparam int               RECIP_SHIFT = 16;
    localparam logic [QTR_W-1:0] TWENTY_FIVE = QTR_W'(25);
    localparam logic [ORD_W-1:0] DAYS_COMMON = ORD_W'(365);

    localparam logic [MONTH_W-1:0] MARCH = MONTH_W'(3);

    // Per-stage load enables handed to the ordinal datapath
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Days in the months before month m of a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] d;
        unique case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ddd_ordinal.sv @@
// Three-stage datapath mapping one date to its ordinal day number.
// Depends on ddd_pkg; stage loads come from the valid chain in the top level.
`default_nettype none

module ddd_ordinal (
    input  wire logic                          aclk,
    input  wire ddd_pkg::stage_en_t            en,
    input  wire logic [ddd_pkg::DAY_W-1:0]     day,
    input  wire logic [ddd_pkg::MONTH_W-1:0]   month,
    input  wire logic [ddd_pkg::YEAR_W-1:0]    year,
    output logic      [ddd_pkg::ORD_W-1:0]     ordinal
);

    // Stage 1: quarter years and reciprocal products
    logic [ddd_pkg::YEAR_W-1:0]  yr_m1;
    logic [ddd_pkg::QTR_W-1:0]   qtr_prev_next;
    logic [ddd_pkg::QTR_W-1:0]   qtr_own_next;
    logic [ddd_pkg::PROD_W-1:0]  prod_prev_next;
    logic [ddd_pkg::PROD_W-1:0]  prod_own_next;

    logic [ddd_pkg::YEAR_W-1:0]  s1_year_reg;
    logic [ddd_pkg::MONTH_W-1:0] s1_month_reg;
    logic [ddd_pkg::DAY_W-1:0]   s1_day_reg;
    logic [ddd_pkg::QTR_W-1:0]   s1_qtr_prev_reg;
    logic [ddd_pkg::QTR_W-1:0]   s1_qtr_own_reg;
    logic [ddd_pkg::PROD_W-1:0]  s1_prod_prev_reg;
    logic [ddd_pkg::PROD_W-1:0]  s1_prod_own_reg;

    assign yr_m1          = year - ddd_pkg::YEAR_W'(1);
    assign qtr_prev_next  = yr_m1[ddd_pkg::YEAR_W-1:2];
    assign qtr_own_next   = year[ddd_pkg::YEAR_W-1:2];
    assign prod_prev_next = ddd_pkg::PROD_W'(qtr_prev_next) * ddd_pkg::PROD_W'(ddd_pkg::RECIP_25);
    assign prod_own_next  = ddd_pkg::PROD_W'(qtr_own_next) * ddd_pkg::PROD_W'(ddd_pkg::RECIP_25);

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            s1_year_reg      <= year;
            s1_month_reg     <= month;
            s1_day_reg       <= day;
            s1_qtr_prev_reg  <= qtr_prev_next;
            s1_qtr_own_reg   <= qtr_own_next;
            s1_prod_prev_reg <= prod_prev_next;
            s1_prod_own_reg  <= prod_own_next;
        end
    end

    // Stage 2: leap count of earlier years, leap flag, whole-year days
    logic [ddd_pkg::CENT_W-1:0]  cent_prev;
    logic [ddd_pkg::CENT_W-1:0]  cent_own;
    logic [ddd_pkg::QTR_W-1:0]   cent_rem;
    logic [ddd_pkg::QTR_W-1:0]   leaps_next;
    logic                        is_leap_next;
    logic [ddd_pkg::ORD_W-1:0]   yr_days_next;

    logic [ddd_pkg::QTR_W-1:0]   s2_leaps_reg;
    logic                        s2_is_leap_reg;
    logic                        s2_yr_nz_reg;
    logic [ddd_pkg::ORD_W-1:0]   s2_yr_days_reg;
    logic [ddd_pkg::MONTH_W-1:0] s2_month_reg;
    logic [ddd_pkg::DAY_W-1:0]   s2_day_reg;

    assign cent_prev = s1_prod_prev_reg[ddd_pkg::RECIP_SHIFT +: ddd_pkg::CENT_W];
    assign cent_own  = s1_prod_own_reg[ddd_pkg::RECIP_SHIFT +: ddd_pkg::CENT_W];
    // leaps through n: n/4 - n/100 + n/400
    assign leaps_next = s1_qtr_prev_reg - ddd_pkg::QTR_W'(cent_prev)
                      + ddd_pkg::QTR_W'(cent_prev[ddd_pkg::CENT_W-1:2]);
    // remainder of quarter years by 25: zero means divisible by 100
    assign cent_rem   = s1_qtr_own_reg - ddd_pkg::QTR_W'(cent_own) * ddd_pkg::TWENTY_FIVE;
    assign is_leap_next = (s1_year_reg[1:0] == 2'd0)
                        && ((cent_rem != '0) || (cent_own[1:0] == 2'd0));
    assign yr_days_next = ddd_pkg::ORD_W'(s1_year_reg) * ddd_pkg::DAYS_COMMON;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            s2_leaps_reg   <= leaps_next;
            s2_is_leap_reg <= is_leap_next;
            s2_yr_nz_reg   <= (s1_year_reg != '0);
            s2_yr_days_reg <= yr_days_next;
            s2_month_reg   <= s1_month_reg;
            s2_day_reg     <= s1_day_reg;
        end
    end

    // Stage 3: sum of years, months and day
    logic [ddd_pkg::ORD_W-1:0] year_part;
    logic [ddd_pkg::ORD_W-1:0] month_part;
    logic [ddd_pkg::ORD_W-1:0] ordinal_next;
    logic [ddd_pkg::ORD_W-1:0] ordinal_reg;

    // year zero counts nothing before it; otherwise year 0 adds its leap day
    assign year_part  = s2_yr_nz_reg
                      ? (s2_yr_days_reg + ddd_pkg::ORD_W'(1) + ddd_pkg::ORD_W'(s2_leaps_reg))
                      : '0;
    assign month_part = ddd_pkg::ORD_W'(ddd_pkg::days_before_month(s2_month_reg))
                      + ddd_pkg::ORD_W'((s2_month_reg >= ddd_pkg::MARCH) && s2_is_leap_reg);
    assign ordinal_next = year_part + month_part + ddd_pkg::ORD_W'(s2_day_reg);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            ordinal_reg <= ordinal_next;
        end
    end

    assign ordinal = ordinal_reg;

endmodule

`default_nettype wire

@@ rtl/date_difference_days_core.sv @@
// Throughput: one date pair per cycle while m_tready is high; the four-stage
// pipeline with per-stage valid bits sets it, and a stalled output still lets
// bubbles upstream fill; m_tdata comes from the stage 4 output register.
// Reset: aresetn (synchronous, active low) clears all valid bits; no clearing pass.
// Top level of the Gregorian date difference core.
// Depends on ddd_pkg, ddd_ordinal and date_difference_days_core_defines.svh.
`default_nettype none

`include "date_difference_days_core_defines.svh"

module date_difference_days_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // s_tdata: first_day[4:0], first_month[8:5], first_year[22:9],
    //          second_day[27:23], second_month[31:28], second_year[45:32], zero[47:46]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ddd_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: day_distance[21:0], zero[23:22]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [ddd_pkg::M_TDATA_W-1:0]     m_tdata
);

    // Valid chain: a stage loads when empty or when its successor moves on
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;
    ddd_pkg::stage_en_t en;

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign en.s3 = rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Two ordinal datapaths, one per date
    logic [ddd_pkg::ORD_W-1:0] ord_a;
    logic [ddd_pkg::ORD_W-1:0] ord_b;

    ddd_ordinal u_ord_first (
        .aclk    (aclk),
        .en      (en),
        .day     (s_tdata[4:0]),
        .month   (s_tdata[8:5]),
        .year    (s_tdata[22:9]),
        .ordinal (ord_a)
    );

    ddd_ordinal u_ord_second (
        .aclk    (aclk),
        .en      (en),
        .day     (s_tdata[27:23]),
        .month   (s_tdata[31:28]),
        .year    (s_tdata[45:32]),
        .ordinal (ord_b)
    );

    // Stage 4: absolute difference into the output register
    logic [ddd_pkg::ORD_W-1:0]  diff;
    logic [ddd_pkg::DIST_W-1:0] dist_reg;

    assign diff = (ord_a >= ord_b) ? (ord_a - ord_b) : (ord_b - ord_a);

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            dist_reg <= diff[ddd_pkg::DIST_W-1:0];
        end
    end

    assign s_tready = rdy1;
    assign m_tvalid = v4_reg;
    assign m_tdata  = {(ddd_pkg::M_TDATA_W - ddd_pkg::DIST_W)'(0), dist_reg};

    // Checks on the valid chain
    `DDD_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, s_tvalid && s_tready, v1_reg)
    `DDD_ASSERT_NOW(a_stall_only_when_full, aclk, aresetn, !s_tready,
                    v1_reg && v2_reg && v3_reg && v4_reg)
    `DDD_ASSERT_NEXT(a_s3_holds_on_stall, aclk, aresetn, v3_reg && v4_reg && !m_tready,
                     v3_reg)

endmodule

`default_nettype wire
